// ===== hdl/miv_pkg.sv =====
// ---------------------------------------------------------------------------
// miv_pkg
// Shared types, constants and the CRC16 byte step for the module image
// validator.
// ---------------------------------------------------------------------------
package miv_pkg;

  // Slot geometry and header markers
  localparam int SLOT_BYTES   = 4096;
  localparam int SLOT_TOTAL   = 16;
  localparam int EMPTY_MARK   = 65535;
  localparam int HDR_BYTES    = 10;
  localparam int CRC_FIELD_BYTES = 2;

  // Byte counter saturates at SLOT_BYTES + 1
  localparam int CNT_W = $clog2(SLOT_BYTES + 2);
  // Width for offset/size/length arithmetic without overflow
  localparam int CMP_W = 17;

  // CRC16 Modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  PAD_BYTE = 8'hFF;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_VERSION_ON = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REQ_TYPE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_NUMBER = 2'd2;

  // Stream payload widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int STATUS_W   = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BAD_SLOT = 3'd2,
    ST_BAD_HDR  = 3'd3,
    ST_SIZE     = 3'd4,
    ST_VERSION  = 3'd5,
    ST_CRC      = 3'd6
  } miv_status_e;

  // Controller to datapath
  typedef struct packed {
    logic take;    // accepted image byte
    logic pad;     // hash one 0xFF padding byte
    logic finish;  // load result, clear image state
  } miv_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pre_ok;      // all checks before the CRC compare pass
    logic pad_needed;  // size is zero and the slot end is not reached
    logic pad_last;    // next padding byte reaches the slot end
  } miv_sts_t;

  // One byte of CRC16 Modbus, reflected
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/miv_ctrl.sv =====
// ---------------------------------------------------------------------------
// miv_ctrl
// Sequencer for the module image validator: byte intake, the final check
// step, the padding walk and the output register handshake.
// ---------------------------------------------------------------------------
module miv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_last_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  miv_pkg::miv_sts_t sts_i,
  output miv_pkg::miv_cmd_t cmd_o
);
  import miv_pkg::*;

  typedef enum logic [1:0] {
    S_RUN,
    S_FINAL,
    S_PAD
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   out_free;

  // Output slot can take a result this cycle
  assign out_free  = !m_valid_q || m_ready_i;
  // Take bytes whenever running; a waiting result only holds the check step
  assign s_ready_o = (state_q == S_RUN);
  assign m_valid_o = m_valid_q;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    cmd_o      = '0;
    case (state_q)
      S_RUN: begin
        cmd_o.take = s_valid_i && s_ready_o;
        if (cmd_o.take && s_last_i) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts_i.pre_ok && sts_i.pad_needed) begin
          state_d = S_PAD;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = S_RUN;
        end
      end
      S_PAD: begin
        cmd_o.pad = 1'b1;
        if (sts_i.pad_last) begin
          state_d = S_FINAL;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

// ===== hdl/miv_datapath.sv =====
// ---------------------------------------------------------------------------
// miv_datapath
// Header capture, running CRC16, byte count, configuration registers,
// image checks and the result register.
// ---------------------------------------------------------------------------
module miv_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [miv_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [miv_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  miv_pkg::miv_cmd_t               cmd_i,
  input  logic [7:0]                      slot_i,
  input  logic [7:0]                      data_byte_i,
  output miv_pkg::miv_sts_t               sts_o,
  output logic [miv_pkg::STATUS_W-1:0]    status_o,
  output logic [15:0]                     crc_o
);
  import miv_pkg::*;

  // Configuration
  logic        ver_on_q;
  logic [15:0] req_type_q;
  logic [15:0] min_number_q;

  // Image state
  logic [15:0]      crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       slot_q, slot_d;
  logic [7:0]       hdr_q [HDR_BYTES];
  logic [7:0]       hdr_d [HDR_BYTES];

  // Result register
  miv_status_e status_q, status_d;
  logic [15:0] out_crc_q, out_crc_d;

  // Header fields, little endian
  logic [15:0] stored_crc, body_offset, img_size, module_type, module_number;
  logic [CMP_W-1:0] len, off, size, slot_room;
  miv_status_e pre_status;

  assign stored_crc    = {hdr_q[1], hdr_q[0]};
  assign body_offset   = {hdr_q[3], hdr_q[2]};
  assign img_size      = {hdr_q[5], hdr_q[4]};
  assign module_type   = {hdr_q[7], hdr_q[6]};
  assign module_number = {hdr_q[9], hdr_q[8]};

  assign len       = CMP_W'(cnt_q);
  assign off       = CMP_W'(body_offset);
  assign size      = CMP_W'(img_size);
  assign slot_room = CMP_W'(SLOT_BYTES) - off;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_on_q     <= 1'b0;
      req_type_q   <= '0;
      min_number_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_VERSION_ON: ver_on_q     <= cfg_wdata_i[0];
        CFG_REQ_TYPE:   req_type_q   <= cfg_wdata_i;
        CFG_MIN_NUMBER: min_number_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Checks ahead of the CRC compare, in priority order
  always_comb begin
    if (slot_q >= 8'(SLOT_TOTAL)) begin
      pre_status = ST_BAD_SLOT;
    end else if (len < CMP_W'(HDR_BYTES) || len > CMP_W'(SLOT_BYTES)) begin
      pre_status = ST_SIZE;
    end else if (body_offset == 16'(EMPTY_MARK)) begin
      pre_status = ST_EMPTY;
    end else if (off < CMP_W'(HDR_BYTES) || off >= CMP_W'(SLOT_BYTES)) begin
      pre_status = ST_BAD_HDR;
    end else if (img_size != '0 && size > slot_room) begin
      pre_status = ST_SIZE;
    end else if (ver_on_q &&
                 (module_type != req_type_q || module_number < min_number_q)) begin
      pre_status = ST_VERSION;
    end else if (off >= len) begin
      pre_status = ST_SIZE;
    end else if (img_size != '0 && len != (off + size)) begin
      pre_status = ST_SIZE;
    end else begin
      pre_status = ST_OK;
    end
  end

  assign sts_o.pre_ok     = (pre_status == ST_OK);
  assign sts_o.pad_needed = (img_size == '0) && (len < CMP_W'(SLOT_BYTES));
  assign sts_o.pad_last   = (cnt_q == CNT_W'(SLOT_BYTES - 1));

  // Advance image state
  always_comb begin
    crc_d     = crc_q;
    cnt_d     = cnt_q;
    slot_d    = slot_q;
    hdr_d     = hdr_q;
    status_d  = status_q;
    out_crc_d = out_crc_q;
    if (cmd_i.finish) begin
      // Load result and clear for the next image
      if (pre_status != ST_OK) begin
        status_d  = pre_status;
        out_crc_d = '0;
      end else begin
        status_d  = (stored_crc != '0 && stored_crc != crc_q) ? ST_CRC : ST_OK;
        out_crc_d = crc_q;
      end
      crc_d  = CRC_INIT;
      cnt_d  = '0;
      slot_d = '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_d[i] = '0;
      end
    end else if (cmd_i.pad) begin
      crc_d = crc16_byte(crc_q, PAD_BYTE);
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.take) begin
      if (cnt_q == '0) begin
        slot_d = slot_i;
      end
      if (cnt_q <= CNT_W'(SLOT_BYTES)) begin
        for (int i = 0; i < HDR_BYTES; i++) begin
          if (cnt_q == CNT_W'(i)) begin
            hdr_d[i] = data_byte_i;
          end
        end
        if (cnt_q >= CNT_W'(CRC_FIELD_BYTES) && cnt_q < CNT_W'(SLOT_BYTES)) begin
          crc_d = crc16_byte(crc_q, data_byte_i);
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // Hold image state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CRC_INIT;
      cnt_q     <= '0;
      slot_q    <= '0;
      status_q  <= ST_OK;
      out_crc_q <= '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_q[i] <= '0;
      end
    end else begin
      crc_q     <= crc_d;
      cnt_q     <= cnt_d;
      slot_q    <= slot_d;
      status_q  <= status_d;
      out_crc_q <= out_crc_d;
      hdr_q     <= hdr_d;
    end
  end

  assign status_o = status_q;
  assign crc_o    = out_crc_q;

endmodule

// ===== hdl/module_image_validator_top.sv =====
// ---------------------------------------------------------------------------
// module_image_validator_top
// Module image validator: header capture, CRC16 Modbus and image checks
// over a byte stream, one status item per image.
// ---------------------------------------------------------------------------
// Bytes of an image are taken at one per clock. After the byte marked last,
// a check step follows and the result item is loaded into the output
// register. When the header's body size is zero and the checks pass, the
// image is padded with 0xFF up to the slot end first: the single byte-wide
// CRC unit hashes one byte a cycle, one per padding byte (SLOT_BYTES minus
// the bytes received), and then the check step runs again. Input is not
// taken during the check step and the padding. A result that the sink does
// not take holds only the check step of the next image; its bytes still flow in.
// Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i.
module module_image_validator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [miv_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [miv_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // Image byte stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [miv_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,  // [7:0] slot, [15:8] data_byte
  input  logic                                s_axis_tlast_i,
  // Result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [miv_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o   // [2:0] status,
                                                               // [18:3] computed_crc
);
  import miv_pkg::*;

  miv_cmd_t            cmd;
  miv_sts_t            sts;
  logic [STATUS_W-1:0] status;
  logic [15:0]         crc;

  miv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  miv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .slot_i      (s_axis_tdata_i[7:0]),
    .data_byte_i (s_axis_tdata_i[15:8]),
    .sts_o       (sts),
    .status_o    (status),
    .crc_o       (crc)
  );

  // Pack result: status low, CRC above, zero fill to whole bytes
  assign m_axis_tdata_o = {{(OUT_DATA_W - STATUS_W - 16){1'b0}}, crc, status};

endmodule

// ===== tb/sv/module_image_validator_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// module_image_validator_top_tb
// Streams module images byte by byte into the validator and checks each
// status/CRC result against an in-bench model of the header capture,
// CRC16 Modbus and image checks, under random gaps, stalls and long
// back-pressure, across several version-check settings.
// ---------------------------------------------------------------------------
module module_image_validator_top_tb;
  import miv_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 600;

  // Header word positions
  localparam int HW_CRC  = 0;
  localparam int HW_OFF  = 1;
  localparam int HW_SIZE = 2;
  localparam int HW_TYPE = 3;
  localparam int HW_NUM  = 4;

  typedef enum {STORE_GOOD, STORE_ZERO, STORE_BAD, STORE_RAW} crc_fill_e;

  typedef struct packed {
    logic [7:0] slot;
    logic [7:0] data;
    logic       last;
  } image_byte_t;

  typedef struct {
    miv_status_e status;
    logic [15:0] crc;
  } verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  s_valid = 1'b0;
  logic [7:0]            s_slot  = '0;
  logic [7:0]            s_byte  = '0;
  logic                  s_last  = 1'b0;
  logic                  s_ready;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;

  // Stimulus and scoreboard
  image_byte_t pending_q[$];
  verdict_t    awaited_q[$];
  image_byte_t next_item;
  verdict_t    want;
  int          bytes_queued = 0;
  int          err_cnt      = 0;
  int          results_seen = 0;
  int          hold_mark    = -1;
  int          hold_left    = 0;
  int          send_gap     = 0;
  int          stall_left   = 0;
  int          cycle_cnt    = 0;
  logic        byte_took    = 1'b0;
  logic        calm         = 1'b0;

  // Predictor copy of configuration and image state
  logic              ver_on   = 1'b0;
  logic [15:0]       req_type = '0;
  logic [15:0]       min_num  = '0;
  logic [15:0]       run_crc  = CRC_INIT;
  logic [CNT_W-1:0]  n_bytes  = '0;
  logic [15:0]       hdr_word [0:4] = '{default: '0};
  logic [7:0]        img_slot = '0;

  module_image_validator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  ({s_byte, s_slot}),  // [7:0] slot, [15:8] data_byte
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)             // [2:0] status, [18:3] computed_crc
  );

  always #5 clk_i = ~clk_i;

  // Reflected CRC16 Modbus, one byte
  function automatic logic [15:0] modbus_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Status and CRC of the image held in the predictor state
  function automatic verdict_t judge_image();
    verdict_t    v;
    int unsigned len, off, size, body;
    logic [15:0] c;
    len      = 32'(n_bytes);
    off      = 32'(hdr_word[HW_OFF]);
    size     = 32'(hdr_word[HW_SIZE]);
    v.crc    = '0;
    v.status = ST_OK;
    if (img_slot >= SLOT_TOTAL) begin
      v.status = ST_BAD_SLOT;
    end else if (len < HDR_BYTES || len > SLOT_BYTES) begin
      v.status = ST_SIZE;
    end else if (off == EMPTY_MARK) begin
      v.status = ST_EMPTY;
    end else if (off < HDR_BYTES || off >= SLOT_BYTES) begin
      v.status = ST_BAD_HDR;
    end else begin
      body = (size != 0) ? size : SLOT_BYTES - off;
      if (body == 0 || body > SLOT_BYTES - off) begin
        v.status = ST_SIZE;
      end else if (ver_on && (hdr_word[HW_TYPE] != req_type ||
                              hdr_word[HW_NUM] < min_num)) begin
        v.status = ST_VERSION;
      end else if (off >= len) begin
        v.status = ST_SIZE;
      end else if (size != 0 && len != off + body) begin
        v.status = ST_SIZE;
      end else begin
        c = run_crc;
        // size zero: pad with 0xFF up to the slot end
        if (size == 0) begin
          for (int i = len; i < SLOT_BYTES; i++) c = modbus_step(c, PAD_BYTE);
        end
        v.crc = c;
        if (hdr_word[HW_CRC] != 0 && hdr_word[HW_CRC] != c) begin
          v.status = ST_CRC;
        end
      end
    end
    return v;
  endfunction

  // Advance the predictor by one accepted item
  task automatic absorb_byte(input logic [7:0] slot, input logic [7:0] b, input logic last);
    if (n_bytes == 0) begin
      img_slot = slot;
    end
    if (n_bytes <= SLOT_BYTES) begin
      if (n_bytes < HDR_BYTES) begin
        hdr_word[n_bytes >> 1][(n_bytes % 2) * 8 +: 8] = b;
      end
      if (n_bytes >= CRC_FIELD_BYTES && n_bytes < SLOT_BYTES) begin
        run_crc = modbus_step(run_crc, b);
      end
      n_bytes++;
    end
    if (last) begin
      awaited_q.push_back(judge_image());
      run_crc  = CRC_INIT;
      n_bytes  = '0;
      hdr_word = '{default: '0};
      img_slot = '0;
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_VERSION_ON: ver_on   = val[0];
      CFG_REQ_TYPE:   req_type = val;
      CFG_MIN_NUMBER: min_num  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Build one image and queue its bytes; the slot field is random after byte 0
  task automatic queue_image(input logic [7:0] slot, input int unsigned len,
                             input logic [15:0] off, input logic [15:0] size,
                             input logic [15:0] typ, input logic [15:0] num,
                             input crc_fill_e how, input int fill);
    logic [7:0]  img[];
    logic [15:0] c, bad;
    int unsigned n;
    image_byte_t ib;
    n   = (len < HDR_BYTES) ? HDR_BYTES : len;
    img = new[n];
    for (int i = 0; i < n; i++) img[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    {img[3], img[2]} = off;
    {img[5], img[4]} = size;
    {img[7], img[6]} = typ;
    {img[9], img[8]} = num;
    c = CRC_INIT;
    for (int i = CRC_FIELD_BYTES; i < n && i < SLOT_BYTES; i++) c = modbus_step(c, img[i]);
    if (size == 0) begin
      for (int i = n; i < SLOT_BYTES; i++) c = modbus_step(c, PAD_BYTE);
    end
    bad = c ^ (16'h1 << $urandom_range(0, 15));
    if (bad == 0) begin
      bad = ~c;
    end
    case (how)
      STORE_GOOD: {img[1], img[0]} = c;
      STORE_ZERO: {img[1], img[0]} = 16'h0000;
      STORE_BAD:  {img[1], img[0]} = bad;
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      ib.slot = (i == 0) ? slot : 8'($urandom);
      ib.data = img[i];
      ib.last = (i == len - 1);
      pending_q.push_back(ib);
    end
    bytes_queued += len;
  endtask

  // Mostly well-formed images, the rest broken headers and plain noise
  task automatic queue_random_image();
    int unsigned kind, len, r;
    logic [15:0] off, size, typ, num;
    logic [7:0]  slot;
    crc_fill_e   how;
    kind = $urandom_range(0, 99);
    r    = $urandom_range(0, 99);
    how  = (r < 70) ? STORE_GOOD : (r < 85) ? STORE_ZERO : STORE_BAD;
    typ  = ($urandom_range(0, 9) != 0) ? req_type : 16'($urandom);
    num  = ($urandom_range(0, 9) != 0) ?
           min_num + 16'($urandom_range(0, 65535 - int'(min_num))) : 16'($urandom);
    if (kind < 70) begin
      slot = 8'($urandom_range(0, SLOT_TOTAL - 1));
      off  = 16'($urandom_range(HDR_BYTES, 24));
      if ($urandom_range(0, 9) == 0) begin
        size = '0;
        len  = off + $urandom_range(1, 40);
      end else begin
        size = 16'($urandom_range(1, 40));
        len  = off + size;
      end
      if ($urandom_range(0, 19) == 0) begin
        len = len + 1;
      end
    end else if (kind < 90) begin
      slot = 8'($urandom_range(0, SLOT_TOTAL + 4));
      case ($urandom_range(0, 3))
        0:       off = 16'($urandom_range(0, 12));
        1:       off = 16'(EMPTY_MARK);
        2:       off = 16'($urandom_range(SLOT_BYTES - 6, SLOT_BYTES + 4));
        default: off = 16'($urandom_range(HDR_BYTES, 70));
      endcase
      size = 16'($urandom_range(0, 60));
      len  = $urandom_range(1, 60);
    end else begin
      slot = 8'($urandom);
      off  = 16'($urandom);
      size = 16'($urandom);
      typ  = 16'($urandom);
      num  = 16'($urandom);
      len  = $urandom_range(1, 40);
      how  = STORE_RAW;
    end
    queue_image(slot, len, off, size, typ, num, how, -1);
  endtask

  task automatic fill_random(input int target);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < target) queue_random_image();
  endtask

  // Wait until every queued item is sent and every result is back
  task automatic wait_idle(input int extra);
    while (pending_q.size() != 0 || s_valid || awaited_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Sender: hold an item until taken, then gap or advance
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (s_valid && !byte_took) begin
      // hold
    end else if (send_gap != 0) begin
      s_valid  <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_q.size() != 0) begin
      next_item = pending_q.pop_front();
      s_valid  <= 1'b1;
      s_slot   <= next_item.slot;
      s_byte   <= next_item.data;
      s_last   <= next_item.last;
      send_gap <= pick_gap();
    end else begin
      s_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus the long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_left != 0 || stall_left != 0) begin
      m_ready <= 1'b0;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end
    end else begin
      m_ready    <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Long back-pressure stretches, and calm windows with no idling
  always @(posedge clk_i) begin
    if ($urandom_range(0, 499) == 0) begin
      calm <= !calm;
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen != hold_mark && (results_seen == 6 || results_seen == 45)) begin
      hold_mark <= results_seen;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Check results first, then feed accepted items to the predictor
  always @(posedge clk_i) begin
    byte_took <= s_valid && s_ready;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        results_seen <= results_seen + 1;
        if (awaited_q.size() == 0) begin
          flag_error($sformatf("result with nothing expected: tdata %h", m_data));
        end else begin
          want = awaited_q.pop_front();
          if (m_data[2:0] != want.status) begin
            flag_error($sformatf("status got %0d want %0d", m_data[2:0], want.status));
          end
          if (m_data[18:3] != want.crc) begin
            flag_error($sformatf("crc got %h want %h", m_data[18:3], want.crc));
          end
        end
      end
      if (s_valid && s_ready) begin
        absorb_byte(s_slot, s_byte, s_last);
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: header, length, slot and CRC cases
    queue_image(8'd0,  16,   16'd10,   16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd15, 16,   16'd10,   16'd6,    16'h0, 16'h0, STORE_ZERO, -1);
    queue_image(8'd3,  20,   16'd10,   16'd10,   16'h0, 16'h0, STORE_BAD,  -1);
    queue_image(8'd1,  20,   16'd10,   16'd0,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd2,  11,   16'd10,   16'd1,    16'h0, 16'h0, STORE_ZERO, 0);
    queue_image(8'd4,  30,   16'd12,   16'd18,   16'h0, 16'h0, STORE_GOOD, 255);
    queue_image(8'd16, 16,   16'd10,   16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd255, 5,   16'd10,   16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd5,  1,    16'd10,   16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd6,  9,    16'd10,   16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd7,  16,   16'hFFFF, 16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd8,  16,   16'd9,    16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd9,  16,   16'd4096, 16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd9,  16,   16'd0,    16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd10, 16,   16'd10,   16'd4087, 16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd11, 50,   16'd100,  16'd5,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd12, 17,   16'd10,   16'd6,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd1,  10,   16'd10,   16'd0,    16'h0, 16'h0, STORE_GOOD, -1);
    queue_image(8'd2,  20,   16'd4095, 16'd0,    16'h0, 16'h0, STORE_GOOD, -1);
    fill_random(250);
    wait_idle(20);

    // Version check on, mid-range type and minimum
    write_reg(CFG_VERSION_ON, 16'd1);
    write_reg(CFG_REQ_TYPE,   16'h1234);
    write_reg(CFG_MIN_NUMBER, 16'h0100);
    @(posedge clk_i);
    queue_image(8'd0,  16, 16'd10,  16'd6, 16'h1234, 16'h0100, STORE_GOOD, -1);
    queue_image(8'd1,  16, 16'd10,  16'd6, 16'h1235, 16'h0100, STORE_GOOD, -1);
    queue_image(8'd2,  16, 16'd10,  16'd6, 16'h1234, 16'h00FF, STORE_GOOD, -1);
    queue_image(8'd3,  16, 16'd10,  16'd6, 16'h1234, 16'hFFFF, STORE_GOOD, -1);
    queue_image(8'd20, 16, 16'd10,  16'd6, 16'h0000, 16'h0000, STORE_GOOD, -1);
    queue_image(8'd4,  50, 16'd100, 16'd5, 16'h0000, 16'h0100, STORE_GOOD, -1);
    fill_random(250);
    wait_idle(20);

    // Version check at the top of both ranges
    write_reg(CFG_REQ_TYPE,   16'hFFFF);
    write_reg(CFG_MIN_NUMBER, 16'hFFFF);
    @(posedge clk_i);
    queue_image(8'd5, 16, 16'd10, 16'd6, 16'hFFFF, 16'hFFFF, STORE_GOOD, -1);
    queue_image(8'd6, 16, 16'd10, 16'd6, 16'hFFFF, 16'hFFFE, STORE_GOOD, -1);
    fill_random(250);
    wait_idle(20);

    // Version check at the bottom of both ranges
    write_reg(CFG_REQ_TYPE,   16'h0000);
    write_reg(CFG_MIN_NUMBER, 16'h0000);
    @(posedge clk_i);
    queue_image(8'd7, 16, 16'd10, 16'd6, 16'h0000, 16'h0000, STORE_GOOD, -1);
    queue_image(8'd8, 16, 16'd10, 16'd6, 16'h0001, 16'h0000, STORE_GOOD, -1);
    fill_random(250);
    wait_idle(20);

    // Version check off again with odd settings left behind
    write_reg(CFG_VERSION_ON, 16'd0);
    write_reg(CFG_REQ_TYPE,   16'($urandom));
    write_reg(CFG_MIN_NUMBER, 16'hFFFF);
    @(posedge clk_i);
    queue_image(8'd9, 16, 16'd10, 16'd6, 16'hA5A5, 16'h0000, STORE_GOOD, -1);
    fill_random(250);

    // Drain, then watch for stray results
    wait_idle(SLOT_BYTES + 64);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/miv_pkg.sv
hdl/miv_ctrl.sv
hdl/miv_datapath.sv
hdl/module_image_validator_top.sv
tb/sv/module_image_validator_top_tb.sv
